FILE: rtl/core/grid_keypoint_suppression_macros.svh
// Assertion macros shared by the checker of grid_keypoint_suppression.
// Needs nothing else; take it in by `include with the bare file name.
`ifndef GRID_KEYPOINT_SUPPRESSION_MACROS_SVH
`define GRID_KEYPOINT_SUPPRESSION_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GKS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/gkp_pkg.sv
// Types and constants of the grid keypoint suppression block.
// Used by gkp_div, grid_keypoint_suppression and gkp_checker; depends on nothing.
package gkp_pkg;

    localparam int COORD_W = 16;   // 12.4 coordinate
    localparam int STR_W   = 16;   // detector response
    localparam int WS_W    = 7;    // window size register
    localparam int DIM_W   = 13;   // image width and height registers
    localparam int BLK_W   = 7;    // block row and column of a read
    localparam int STEP_W  = WS_W + 4;      // window size in 7.4
    localparam int IDX_W   = COORD_W - 4;   // grid index from a coordinate
    localparam int PROD_W  = IDX_W + 1 + WS_W;
    localparam int BND_W   = PROD_W + 1;
    localparam int CFG_W   = DIM_W;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = COORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [WS_W-1:0] WS_RESET = 7'd8;
    localparam logic [DIM_W-1:0] DIM_RESET = 13'd1024;

    typedef struct packed {
        logic              valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [STR_W-1:0]   s;
    } t_entry;

    typedef struct packed {
        logic [COORD_W-1:0] quot;
        logic [STEP_W-1:0]  rem;
    } t_div_res;

endpackage

FILE: rtl/core/grid_keypoint_suppression.sv
// Grid non-maximum suppression of keypoints: top level with block store and sequencer.
// Depends on gkp_pkg and gkp_div.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ------------------------------------------
//  item in   input      i_valid / o_stall    i_op, i_point_x, i_point_y, i_strength,
//                                            i_block_row, i_block_col
//  result    output     o_valid / i_stall    o_found, o_kept_x, o_kept_y, o_kept_strength
//  config    input      i_cfg_we             i_cfg_index, i_cfg_data
//
// An offer holds o_stall through two divider passes (x, then y), four bound checks on the
// shared multiplier, one pick per candidate block and one read-modify-write per block taken;
// it skips the checks and blocks when a coordinate has no block in reach.
// A read holds o_stall through S_RDW and S_RESP (only S_RESP out of range); o_valid rises as
// S_RESP passes the result on, later while the output register still holds an unaccepted one.
// After reset a clearing pass empties one block a cycle, all MAX_BLOCK_ROWS * MAX_BLOCK_COLS
// blocks (16384 at the defaults); configuration writes are taken at any time.
module grid_keypoint_suppression #(
    parameter int MAX_BLOCK_ROWS = 128,
    parameter int MAX_BLOCK_COLS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item in
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [gkp_pkg::COORD_W-1:0]   i_point_x,
    input  logic [gkp_pkg::COORD_W-1:0]   i_point_y,
    input  logic [gkp_pkg::STR_W-1:0]     i_strength,
    input  logic [gkp_pkg::BLK_W-1:0]     i_block_row,
    input  logic [gkp_pkg::BLK_W-1:0]     i_block_col,
    // result
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [gkp_pkg::COORD_W-1:0]   o_kept_x,
    output logic [gkp_pkg::COORD_W-1:0]   o_kept_y,
    output logic [gkp_pkg::STR_W-1:0]     o_kept_strength,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [gkp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gkp_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int DEPTH = MAX_BLOCK_ROWS * MAX_BLOCK_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_CLR,   // clearing pass after reset
        S_IDLE,  // ready for an item
        S_DIVX,  // dividing x by the window step
        S_DIVY,  // dividing y by the window step
        S_CHK,   // bound checks of the candidate rows and columns
        S_ITER,  // pick the next candidate block, issue its read
        S_RMW,   // compare and write back
        S_RDW,   // read transaction: take entry, clear it
        S_RESP   // hand the result to the output register
    } t_state;

    // Flat store address of a block; callers keep the row below MAX_BLOCK_ROWS.
    function automatic logic [AW-1:0] blk_addr(input logic [gkp_pkg::IDX_W:0] row,
                                               input logic [gkp_pkg::IDX_W:0] col);
        return AW'(32'(row) * 32'(MAX_BLOCK_COLS) + 32'(col));
    endfunction

    // ---------------------------------------------------------------- registers
    t_state                       r_state, n_state;
    logic [gkp_pkg::WS_W-1:0]     r_ws;
    logic [gkp_pkg::DIM_W-1:0]    r_img_w, r_img_h;
    logic [gkp_pkg::COORD_W-1:0]  r_px, n_px, r_py, n_py;
    logic [gkp_pkg::STR_W-1:0]    r_s, n_s;
    logic [gkp_pkg::IDX_W-1:0]    r_clo, n_clo, r_rlo, n_rlo;
    logic                         r_cspan, n_cspan, r_rspan, n_rspan;
    logic                         r_xemp, n_xemp;
    logic [2:0]                   r_cnt, n_cnt;
    logic [gkp_pkg::IDX_W:0]      r_sel, n_sel;
    logic [gkp_pkg::PROD_W-1:0]   r_prod, n_prod;
    logic [3:0]                   r_ok, n_ok;
    logic [1:0]                   r_pair, n_pair;
    logic [AW-1:0]                r_addr, n_addr;
    logic [AW-1:0]                r_clr_addr, n_clr_addr;
    gkp_pkg::t_entry              r_res, n_res;
    logic                         r_out_valid, n_out_valid;
    gkp_pkg::t_entry              r_out, n_out;

    // block store
    gkp_pkg::t_entry              r_mem [DEPTH];
    gkp_pkg::t_entry              r_rd_data;
    logic                         mem_we;
    logic [AW-1:0]                mem_wa, rd_addr;
    gkp_pkg::t_entry              mem_wd;

    // divider
    logic                         div_start, div_done;
    logic [gkp_pkg::COORD_W-1:0]  div_dividend;
    gkp_pkg::t_div_res            div_res;

    // ---------------------------------------------------------- window geometry
    logic [gkp_pkg::WS_W-1:0]     wse;     // window size, zero taken as one
    logic [gkp_pkg::WS_W-1:0]     half;
    logic [gkp_pkg::STEP_W-1:0]   step;    // window size in 7.4
    logic [gkp_pkg::STEP_W-1:0]   reach;   // twice the half window in 7.4
    logic                         even;

    assign wse   = (r_ws == '0) ? gkp_pkg::WS_W'(1) : r_ws;
    assign half  = wse >> 1;
    assign step  = {wse, 4'b0000};
    assign reach = {wse[gkp_pkg::WS_W-1:1], 5'b00000};
    assign even  = ~wse[0];

    // ------------------------------------------------------------ index range
    // hi is the quotient; lo is the quotient, one less on an exact multiple of
    // an even step, or zero near the origin. A remainder past the reach leaves
    // no block in range. hi - lo never exceeds one.
    logic [gkp_pkg::COORD_W-1:0]  cur_p;
    logic [gkp_pkg::IDX_W-1:0]    q_hi, q_lo;
    logic                         p_near, q_dec, q_emp, q_span;

    always_comb begin
        cur_p  = (r_state == S_DIVX) ? r_px : r_py;
        q_hi   = div_res.quot[gkp_pkg::IDX_W-1:0];
        p_near = (cur_p <= gkp_pkg::COORD_W'(reach));
        q_dec  = !p_near && even && (div_res.rem == '0);
        q_emp  = !p_near && (div_res.rem > reach);
        q_lo   = p_near ? '0 : q_hi - gkp_pkg::IDX_W'(q_dec);
        q_span = (q_hi != q_lo);
    end

    // ---------------------------------------------------------- bound checks
    logic [gkp_pkg::IDX_W:0]      chk_sel;
    logic [1:0]                   chk_k;
    logic                         chk_ok;
    logic [gkp_pkg::BND_W-1:0]    chk_reach;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    chk_sel = {1'b0, r_rlo};
            2'd1:    chk_sel = {1'b0, r_rlo} + 1'b1;
            2'd2:    chk_sel = {1'b0, r_clo};
            default: chk_sel = {1'b0, r_clo} + 1'b1;
        endcase
        chk_k     = 2'(r_cnt - 3'd1);
        chk_reach = gkp_pkg::BND_W'(r_prod) + gkp_pkg::BND_W'(half)
                  + gkp_pkg::BND_W'(wse);
        // centre plus one window must stay inside the image
        chk_ok = (32'(r_sel) < (chk_k[1] ? MAX_BLOCK_COLS : MAX_BLOCK_ROWS))
              && (chk_reach < gkp_pkg::BND_W'(chk_k[1] ? r_img_w : r_img_h));
    end

    // ------------------------------------------------------- candidate blocks
    logic                         it_row, it_col, it_active, it_take;
    logic [gkp_pkg::IDX_W:0]      it_r, it_c;
    logic                         in_accept, rd_in_range;

    always_comb begin
        it_row    = r_pair[1];
        it_col    = r_pair[0];
        it_r      = {1'b0, r_rlo} + (gkp_pkg::IDX_W+1)'(it_row);
        it_c      = {1'b0, r_clo} + (gkp_pkg::IDX_W+1)'(it_col);
        it_active = (!it_row || r_rspan) && (!it_col || r_cspan)
                 && r_ok[{1'b0, it_row}] && r_ok[{1'b1, it_col}];
        // the earlier keypoint keeps a tie
        it_take   = !r_rd_data.valid || (r_s > r_rd_data.s);
        in_accept = i_valid && !o_stall;
        rd_in_range = (32'(i_block_row) < MAX_BLOCK_ROWS)
                   && (32'(i_block_col) < MAX_BLOCK_COLS);
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state     = r_state;
        n_px        = r_px;
        n_py        = r_py;
        n_s         = r_s;
        n_clo       = r_clo;
        n_rlo       = r_rlo;
        n_cspan     = r_cspan;
        n_rspan     = r_rspan;
        n_xemp      = r_xemp;
        n_cnt       = r_cnt;
        n_sel       = r_sel;
        n_prod      = r_prod;
        n_ok        = r_ok;
        n_pair      = r_pair;
        n_addr      = r_addr;
        n_clr_addr  = r_clr_addr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_wa      = r_addr;
        mem_wd      = '0;
        rd_addr     = r_addr;
        div_start   = 1'b0;
        div_dividend = r_py;

        // drop the result once the far side takes it
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                mem_we     = 1'b1;
                mem_wa     = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                rd_addr = blk_addr((gkp_pkg::IDX_W+1)'(i_block_row),
                                   (gkp_pkg::IDX_W+1)'(i_block_col));
                if (in_accept) begin
                    n_px = i_point_x;
                    n_py = i_point_y;
                    n_s  = i_strength;
                    if (i_op == gkp_pkg::OP_OFFER) begin
                        div_start    = 1'b1;
                        div_dividend = i_point_x;
                        n_state      = S_DIVX;
                    end else if (rd_in_range) begin
                        n_addr  = rd_addr;
                        n_state = S_RDW;
                    end else begin
                        n_res   = '0;
                        n_state = S_RESP;
                    end
                end
            end
            S_DIVX: begin
                if (div_done) begin
                    n_clo     = q_lo;
                    n_cspan   = q_span;
                    n_xemp    = q_emp;
                    div_start = 1'b1;
                    n_state   = S_DIVY;
                end
            end
            S_DIVY: begin
                if (div_done) begin
                    n_rlo   = q_lo;
                    n_rspan = q_span;
                    n_cnt   = '0;
                    n_state = (r_xemp || q_emp) ? S_IDLE : S_CHK;
                end
            end
            S_CHK: begin
                // multiply this candidate, compare the previous one
                n_sel  = chk_sel;
                n_prod = gkp_pkg::PROD_W'(chk_sel) * gkp_pkg::PROD_W'(wse);
                if (r_cnt != '0) begin
                    n_ok[chk_k] = chk_ok;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd4) begin
                    n_pair  = '0;
                    n_state = S_ITER;
                end
            end
            S_ITER: begin
                rd_addr = blk_addr(it_r, it_c);
                if (it_active) begin
                    n_addr  = rd_addr;
                    n_state = S_RMW;
                end else if (r_pair == 2'd3) begin
                    n_state = S_IDLE;
                end else begin
                    n_pair = r_pair + 1'b1;
                end
            end
            S_RMW: begin
                mem_we = it_take;
                mem_wd = '{valid: 1'b1, x: r_px, y: r_py, s: r_s};
                n_pair = r_pair + 1'b1;
                n_state = (r_pair == 2'd3) ? S_IDLE : S_ITER;
            end
            S_RDW: begin
                // hand back the entry and leave the block empty
                mem_we  = 1'b1;
                n_res   = r_rd_data.valid ? r_rd_data : '0;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || !i_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_ws        <= gkp_pkg::WS_RESET;
            r_img_w     <= gkp_pkg::DIM_RESET;
            r_img_h     <= gkp_pkg::DIM_RESET;
            r_cnt       <= '0;
            r_pair      <= '0;
            r_ok        <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_pair      <= n_pair;
            r_ok        <= n_ok;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gkp_pkg::CFG_WINDOW_SIZE:  r_ws    <= i_cfg_data[gkp_pkg::WS_W-1:0];
                    gkp_pkg::CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                    gkp_pkg::CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_px    <= n_px;
        r_py    <= n_py;
        r_s     <= n_s;
        r_clo   <= n_clo;
        r_rlo   <= n_rlo;
        r_cspan <= n_cspan;
        r_rspan <= n_rspan;
        r_xemp  <= n_xemp;
        r_sel   <= n_sel;
        r_prod  <= n_prod;
        r_addr  <= n_addr;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // ------------------------------------------------------------- block store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    gkp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (step),
        .o_done     (div_done),
        .o_res      (div_res)
    );

    // ----------------------------------------------------------------- outputs
    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_found         = r_out.valid;
    assign o_kept_x        = r_out.x;
    assign o_kept_y        = r_out.y;
    assign o_kept_strength = r_out.s;

endmodule

FILE: rtl/core/gkp_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on gkp_pkg for widths and the result type.
module gkp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [gkp_pkg::COORD_W-1:0] i_dividend,
    input  logic [gkp_pkg::STEP_W-1:0]  i_divisor,
    output logic                       o_done,
    output gkp_pkg::t_div_res          o_res
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [gkp_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [gkp_pkg::COORD_W-1:0]   r_quot, n_quot;
    logic [gkp_pkg::STEP_W-1:0]    r_rem, n_rem;
    logic [gkp_pkg::STEP_W-1:0]    r_dvs, n_dvs;
    logic [gkp_pkg::STEP_W:0]      trial;
    logic                          qbit;

    always_comb begin
        trial  = {r_rem, r_quot[gkp_pkg::COORD_W-1]};
        qbit   = (trial >= {1'b0, r_dvs});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = gkp_pkg::DIV_CNT_W'(gkp_pkg::DIV_STEPS);
            n_quot = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract where it fits
            n_rem  = qbit ? gkp_pkg::STEP_W'(trial - {1'b0, r_dvs})
                          : trial[gkp_pkg::STEP_W-1:0];
            n_quot = {r_quot[gkp_pkg::COORD_W-2:0], qbit};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == gkp_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

FILE: rtl/core/gkp_checker.sv
// Port-level checker for grid_keypoint_suppression, bound to the top level.
// Depends on gkp_pkg and grid_keypoint_suppression_macros.svh.
`include "grid_keypoint_suppression_macros.svh"

module gkp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_found,
    input logic [gkp_pkg::COORD_W-1:0]   o_kept_x,
    input logic [gkp_pkg::COORD_W-1:0]   o_kept_y,
    input logic [gkp_pkg::STR_W-1:0]     o_kept_strength
);

    // hold a stalled result
    `GKS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_found) && $stable(o_kept_x) && $stable(o_kept_y) && $stable(o_kept_strength), "stalled result changed")

    // an empty block reads back as zeros
    `GKS_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_valid && !o_found, o_kept_x == '0 && o_kept_y == '0 && o_kept_strength == '0, "empty result carries data")

    // every accepted transaction leaves the block busy in the cycle after acceptance
    `GKS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "ready straight after acceptance")

    // a result appears only from a busy block
    `GKS_ASSERT_SAME(a_result_from_busy, i_clk, i_rst_n, $rose(o_valid), $past(o_stall), "result while idle")

endmodule

bind grid_keypoint_suppression gkp_checker u_gkp_checker (.*);
